// ----- hw/rtl/hmac_md5_truncated_key_top_macros.svh -----
// Assertion macros for the checker file of the HMAC-MD5 block.
// Depends on nothing; the user module must have i_clk and i_rst_n in scope.
`ifndef HMAC_MD5_TRUNCATED_KEY_TOP_MACROS_SVH
`define HMAC_MD5_TRUNCATED_KEY_TOP_MACROS_SVH

// Clocked check, disabled while reset is held.
`define HMK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hmk assertion failed");

// Same check with a message of the caller's choice.
`define HMK_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// ----- hw/rtl/hmk_pkg.sv -----
// Package of the HMAC-MD5 block: sequencer codes, MD5 constants and helpers.
// Depends on nothing; used by the top level and the checker.
package hmk_pkg;

    localparam int KeyDepth   = 64;
    localparam int BlockWords = 16;

    // Input kinds.
    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_MSG = 2'd1;
    localparam logic [1:0] KIND_FIN = 2'd2;

    // Computation phase.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_KEY  = 2'd1;
    localparam logic [1:0] PH_MSG  = 2'd2;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KRD  = 4'd1;
    localparam logic [3:0] S_KAB  = 4'd2;
    localparam logic [3:0] S_MSG  = 4'd3;
    localparam logic [3:0] S_P80  = 4'd4;
    localparam logic [3:0] S_PZ   = 4'd5;
    localparam logic [3:0] S_PL   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_INB  = 4'd8;
    localparam logic [3:0] S_CPRE = 4'd9;
    localparam logic [3:0] S_CRND = 4'd10;
    localparam logic [3:0] S_CEND = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [7:0] PAD_IN  = 8'h36;
    localparam logic [7:0] PAD_OUT = 8'h5c;
    localparam logic [7:0] PAD_ONE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] MD_IV [4] = '{32'h67452301, 32'hefcdab89,
                                          32'h98badcfe, 32'h10325476};

    localparam logic [31:0] MD_T [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

    localparam logic [4:0] MD_S [16] = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
                                         5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

    // Message word index used by a round.
    function automatic logic [3:0] md_g(input logic [5:0] rnd);
        logic [3:0] i;
        logic [3:0] g;
        i = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i;
            2'd1:    g = 4'((i << 2) + i + 4'd1);
            2'd2:    g = 4'((i << 1) + i + 4'd5);
            default: g = 4'((i << 3) - i);
        endcase
        return g;
    endfunction

    // Rotate left by a round's shift amount.
    function automatic logic [31:0] md_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

// ----- hw/rtl/hmk_if.sv -----
// Handshake interfaces of the HMAC-MD5 block: input item and digest byte.
// Depends on nothing.
interface hmk_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface hmk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic [3:0] byte_index;
    logic       last;
    modport source (output valid, digest_byte, byte_index, last, input ready);
    modport sink   (input valid, digest_byte, byte_index, last, output ready);
endinterface

// ----- hw/rtl/hmk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hmk_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/hmac_md5_truncated_key_top.sv -----
// Channel   Dir  Beat payload                      Accepted when
// i_in      in   kind, data_byte                   valid && ready
// o_out     out  digest_byte, byte_index, last     valid && ready
//
// A key byte is stored in the key RAM; a message byte is absorbed in S_MSG, and
// each 64th byte starts the MD5 compression (one round a cycle through the block
// RAM). The first message byte or a finish after the key pads the key (read in
// S_KRD, absorbed in S_KAB) and runs one compression. A finish runs padding, the
// outer hash and then 16 output beats; input is held off until the last beat.
// Reset is synchronous, active low; the output may stall for any time.
// Depends on hmk_pkg, hmk_if and hmk_ram.
module hmac_md5_truncated_key_top
    import hmk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hmk_in_if.sink            i_in,
    hmk_out_if.source         o_out
);
    logic [3:0]  r_state, n_state;
    logic [3:0]  r_ret, n_ret;
    logic [3:0]  r_after, n_after;
    logic [1:0]  r_phase, n_phase;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_idx, n_idx;
    logic [5:0]  r_rnd, n_rnd;
    logic [3:0]  r_oidx, n_oidx;
    logic        r_outer, n_outer;
    logic [7:0]  r_pad, n_pad;
    logic [7:0]  r_data, n_data;
    logic [63:0] r_bitlen, n_bitlen;
    logic [63:0] r_len, n_len;
    logic [23:0] r_wacc, n_wacc;
    logic [127:0] r_inner, n_inner;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;

    logic        key_we;
    logic [5:0]  key_waddr;
    logic [7:0]  key_rdata;
    logic        bb_we;
    logic [3:0]  bb_waddr, bb_raddr;
    logic [31:0] bb_wdata, bb_rdata;

    logic        ab_en;
    logic [7:0]  ab_byte;
    logic [3:0]  ab_next;
    logic [5:0]  pos;
    logic [6:0]  eff_cnt;
    logic [31:0] f, sum;
    logic [7:0]  key_byte;

    hmk_ram #(.Width(8), .Depth(KeyDepth)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(i_in.data_byte),
        .i_raddr(r_idx),
        .o_rdata(key_rdata)
    );

    hmk_ram #(.Width(32), .Depth(BlockWords)) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (bb_we),
        .i_waddr(bb_waddr),
        .i_wdata(bb_wdata),
        .i_raddr(bb_raddr),
        .o_rdata(bb_rdata)
    );

    assign pos      = r_bitlen[8:3];
    assign eff_cnt  = (r_phase != PH_KEY) ? 7'd0 : r_cnt;
    assign key_we   = i_in.valid && i_in.ready && (i_in.kind == KIND_KEY) && !eff_cnt[6];
    assign key_waddr = eff_cnt[5:0];
    // Entries at or past the fill count read as zero.
    assign key_byte = (({1'b0, r_idx} < r_cnt) ? key_rdata : 8'd0) ^ r_pad;

    // MD5 round function, summed with the registered message word.
    always_comb begin
        case (r_rnd[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + MD_T[r_rnd] + bb_rdata;
    end

    // Handshake outputs.
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_byte = 8'(r_chain[r_oidx[3:2]] >> {r_oidx[1:0], 3'b000});
    assign o_out.byte_index  = r_oidx;
    assign o_out.last        = (r_oidx == 4'd15);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_after  = r_after;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_outer  = r_outer;
        n_pad    = r_pad;
        n_data   = r_data;
        n_bitlen = r_bitlen;
        n_len    = r_len;
        n_wacc   = r_wacc;
        n_inner  = r_inner;
        n_chain  = r_chain;
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        ab_en    = 1'b0;
        ab_byte  = 8'd0;
        ab_next  = S_IDLE;
        bb_we    = 1'b0;
        bb_waddr = pos[5:2];
        bb_wdata = 32'd0;
        bb_raddr = md_g(6'd0);

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_data = i_in.data_byte;
                    if (i_in.kind == KIND_KEY) begin
                        n_phase = PH_KEY;
                        n_cnt   = eff_cnt[6] ? eff_cnt : 7'(eff_cnt + 7'd1);
                    end else if (i_in.kind == KIND_MSG || i_in.kind == KIND_FIN) begin
                        n_state = (i_in.kind == KIND_MSG) ? S_MSG : S_P80;
                        if (r_phase != PH_MSG) begin
                            n_after  = n_state;
                            n_state  = S_KRD;
                            n_chain  = MD_IV;
                            n_bitlen = 64'd0;
                            n_idx    = 6'd0;
                            n_pad    = PAD_IN;
                            n_outer  = 1'b0;
                            n_phase  = PH_MSG;
                        end
                    end
                end
            end
            S_KRD: n_state = S_KAB;
            S_KAB: begin
                ab_en   = 1'b1;
                ab_byte = key_byte;
                ab_next = (r_idx == 6'd63) ? r_after : S_KRD;
                n_idx   = 6'(r_idx + 6'd1);
            end
            S_MSG: begin
                ab_en   = 1'b1;
                ab_byte = r_data;
                ab_next = S_IDLE;
            end
            S_P80: begin
                n_len   = r_bitlen;
                ab_en   = 1'b1;
                ab_byte = PAD_ONE;
                ab_next = S_PZ;
            end
            S_PZ: begin
                if (pos == LEN_POS) begin
                    n_idx   = 6'd0;
                    n_state = S_PL;
                end else begin
                    ab_en   = 1'b1;
                    ab_next = S_PZ;
                end
            end
            S_PL: begin
                ab_en   = 1'b1;
                ab_byte = 8'(r_len >> {r_idx[2:0], 3'b000});
                ab_next = (r_idx[2:0] == 3'd7) ? S_FIN : S_PL;
                n_idx   = 6'(r_idx + 6'd1);
            end
            S_FIN: begin
                if (!r_outer) begin
                    n_inner  = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};
                    n_chain  = MD_IV;
                    n_bitlen = 64'd0;
                    n_outer  = 1'b1;
                    n_idx    = 6'd0;
                    n_pad    = PAD_OUT;
                    n_after  = S_INB;
                    n_state  = S_KRD;
                end else begin
                    n_oidx  = 4'd0;
                    n_state = S_OUT;
                end
            end
            S_INB: begin
                ab_en   = 1'b1;
                ab_byte = 8'(r_inner >> {r_idx[3:0], 3'b000});
                ab_next = (r_idx[3:0] == 4'd15) ? S_P80 : S_INB;
                n_idx   = 6'(r_idx + 6'd1);
            end
            S_CPRE: begin
                n_a = r_chain[0];
                n_b = r_chain[1];
                n_c = r_chain[2];
                n_d = r_chain[3];
                n_rnd   = 6'd0;
                n_state = S_CRND;
            end
            S_CRND: begin
                bb_raddr = md_g(6'(r_rnd + 6'd1));
                n_a = r_d;
                n_d = r_c;
                n_c = r_b;
                n_b = r_b + md_rotl(sum, MD_S[{r_rnd[5:4], r_rnd[1:0]}]);
                n_rnd = 6'(r_rnd + 6'd1);
                if (r_rnd == 6'd63) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_state    = r_ret;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_oidx = 4'(r_oidx + 4'd1);
                    if (r_oidx == 4'd15) begin
                        n_cnt   = 7'd0;
                        n_phase = PH_IDLE;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Absorb one byte into the block; a full block starts a compression.
        if (ab_en) begin
            n_bitlen = r_bitlen + 64'd8;
            if (pos[1:0] == 2'd3) begin
                bb_we    = 1'b1;
                bb_wdata = {ab_byte, r_wacc};
            end else begin
                n_wacc = r_wacc;
                n_wacc[{pos[1:0], 3'b000} +: 8] = ab_byte;
            end
            if (pos == 6'd63) begin
                n_ret   = ab_next;
                n_state = S_CPRE;
            end else begin
                n_state = ab_next;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_after  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_cnt    <= 7'd0;
            r_idx    <= 6'd0;
            r_rnd    <= 6'd0;
            r_oidx   <= 4'd0;
            r_outer  <= 1'b0;
            r_bitlen <= 64'd0;
            r_chain  <= MD_IV;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_after  <= n_after;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
            r_outer  <= n_outer;
            r_bitlen <= n_bitlen;
            r_chain  <= n_chain;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pad   <= n_pad;
        r_data  <= n_data;
        r_len   <= n_len;
        r_wacc  <= n_wacc;
        r_inner <= n_inner;
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end
endmodule

// ----- hw/rtl/hmk_check.sv -----
// Port-level checker of the HMAC-MD5 block and its bind to the top level.
// Depends on hmk_pkg and the assertion macro header.
`include "hmac_md5_truncated_key_top_macros.svh"
module hmk_check
    import hmk_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [3:0] i_out_index,
    input logic       i_out_last
);
    logic       beat_more;
    logic [3:0] idx_inc;

    // A digest beat that is taken and is not the last, and the index that must follow it.
    assign beat_more = i_out_valid && i_out_ready && !i_out_last;
    assign idx_inc   = 4'(i_out_index + 4'd1);

    // The last flag marks exactly the final digest byte.
    `HMK_ASSERT_MSG(a_last_idx, i_out_valid |-> (i_out_last == (i_out_index == 4'd15)), "bad last")
    // No input beat is taken while digest beats are pending.
    `HMK_ASSERT(a_no_overlap, i_out_valid |-> !i_in_ready)
    // Digest beats follow each other with rising index.
    `HMK_ASSERT(a_idx_step, beat_more |=> i_out_valid && (i_out_index == $past(idx_inc)))
    // A stalled digest beat holds its byte.
    `HMK_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
endmodule

bind hmac_md5_truncated_key_top hmk_check u_hmk_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_byte (o_out.digest_byte),
    .i_out_index(o_out.byte_index),
    .i_out_last (o_out.last)
);

// ----- tb/sv/tb_hmac_md5_truncated_key_top.sv -----
// Testbench of the HMAC-MD5 block with truncated key: directed cases, random sessions, then back-pressure.
// Depends on hmk_pkg, hmk_if and the top level hmac_md5_truncated_key_top.
module tb_hmac_md5_truncated_key_top;
    import hmk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic [3:0] byte_index;
        logic       last;
    } t_digest_beat;

    localparam int CycleLimit = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hmk_in_if  in_ch ();
    hmk_out_if out_ch ();

    hmac_md5_truncated_key_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [7:0]  key_mem [64];
    int          key_len;
    logic [1:0]  sess_phase;
    logic [7:0]  blk [64];
    logic [31:0] hstate [4];
    logic [63:0] nbits;

    t_digest_beat digest_q [$];
    int  err_count = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  recv_hold_cycles = 0;

    // Mismatch report.
    task automatic report(input string what);
        err_count++;
        $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    // One MD5 compression of the block buffer.
    function automatic void md5_compress();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, tmp, sum;
        int g, r;
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = hstate[0]; b = hstate[1]; c = hstate[2]; d = hstate[3];
        for (int i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
            endcase
            tmp = d; d = c; c = b;
            sum = a + f + MD_T[i] + m[g];
            b = b + ((sum << MD_S[r*4 + i%4]) | (sum >> (32 - MD_S[r*4 + i%4])));
            a = tmp;
        end
        hstate[0] += a; hstate[1] += b; hstate[2] += c; hstate[3] += d;
    endfunction

    function automatic void md5_begin();
        for (int i = 0; i < 4; i++) hstate[i] = MD_IV[i];
        nbits = '0;
    endfunction

    function automatic void md5_absorb(input logic [7:0] v);
        int pos;
        pos = int'(nbits[8:3]);
        blk[pos] = v;
        nbits += 64'd8;
        if (pos == 63) md5_compress();
    endfunction

    function automatic void md5_close(output logic [7:0] dig [16]);
        logic [63:0] len;
        len = nbits;
        md5_absorb(PAD_ONE);
        while (nbits[8:3] != LEN_POS) md5_absorb(8'h00);
        for (int i = 0; i < 8; i++) md5_absorb(len[8*i +: 8]);
        for (int i = 0; i < 16; i++) dig[i] = hstate[i/4][8*(i%4) +: 8];
    endfunction

    function automatic void drop_key();
        for (int i = 0; i < 64; i++) key_mem[i] = 8'h00;
        key_len = 0;
    endfunction

    function automatic void open_inner();
        md5_begin();
        for (int i = 0; i < 64; i++) md5_absorb(key_mem[i] ^ PAD_IN);
        sess_phase = PH_MSG;
    endfunction

    // Expected digest bytes for one accepted input beat.
    function automatic void predict_hmac(input logic [1:0] kind, input logic [7:0] data);
        logic [7:0] inner [16];
        logic [7:0] outer [16];
        t_digest_beat bt;
        if (kind == KIND_KEY) begin
            if (sess_phase != PH_KEY) begin
                drop_key();
                sess_phase = PH_KEY;
            end
            if (key_len < 64) begin
                key_mem[key_len] = data;
                key_len++;
            end
        end else if (kind == KIND_MSG) begin
            if (sess_phase != PH_MSG) open_inner();
            md5_absorb(data);
        end else if (kind == KIND_FIN) begin
            if (sess_phase != PH_MSG) open_inner();
            md5_close(inner);
            md5_begin();
            for (int i = 0; i < 64; i++) md5_absorb(key_mem[i] ^ PAD_OUT);
            for (int i = 0; i < 16; i++) md5_absorb(inner[i]);
            md5_close(outer);
            for (int i = 0; i < 16; i++) begin
                bt.digest_byte = outer[i];
                bt.byte_index = 4'(i);
                bt.last = (i == 15);
                digest_q.push_back(bt);
            end
            drop_key();
            sess_phase = PH_IDLE;
        end
    endfunction

    // Send one beat, idling at random beforehand. Valid stays high across
    // back-to-back beats and drops only while idling or draining.
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.data_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_hmac(kind, data);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Cycle count and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_hmac_md5_truncated_key_top: done, errors");
            $finish;
        end
    end

    // Receiver readiness, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (recv_hold) begin
            out_ch.ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles + 1;
            if (recv_hold_cycles >= 3000) begin
                recv_hold <= 1'b0;
                recv_hold_cycles <= 0;
            end
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each digest beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_beat exp_bt;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_q.size() == 0) begin
                report($sformatf("unexpected beat idx %0d", out_ch.byte_index));
            end else begin
                exp_bt = digest_q.pop_front();
                if (out_ch.digest_byte !== exp_bt.digest_byte)
                    report($sformatf("digest_byte %h, want %h (idx %0d)",
                                     out_ch.digest_byte, exp_bt.digest_byte, exp_bt.byte_index));
                if (out_ch.byte_index !== exp_bt.byte_index)
                    report($sformatf("byte_index %0d, want %0d",
                                     out_ch.byte_index, exp_bt.byte_index));
                if (out_ch.last !== exp_bt.last)
                    report($sformatf("last %b, want %b", out_ch.last, exp_bt.last));
            end
        end
    end

    // Directed: empty key, long key, message while idle, finish while idle, kind 3.
    task automatic test_directed();
        send_beat(KIND_FIN, 8'h00);
        send_beat(KIND_MSG, 8'hff);
        send_beat(KIND_FIN, 8'hff);
        for (int i = 0; i < 3; i++) send_beat(KIND_KEY, 8'(i * 85));
        send_beat(KIND_MSG, 8'h00);
        send_beat(KIND_MSG, 8'hff);
        send_beat(2'd3, 8'h5a);
        send_beat(KIND_FIN, 8'h00);
        send_beat(KIND_KEY, 8'hff);
        send_beat(KIND_FIN, 8'h00);
        // Key longer than 64 bytes is cut.
        for (int i = 0; i < 70; i++) send_beat(KIND_KEY, 8'(255 - i));
        send_beat(KIND_MSG, 8'h01);
        send_beat(KIND_FIN, 8'h00);
        wait_drained();
    endtask

    // Random sessions: mostly well formed, some noise.
    task automatic test_random(input int n_items);
        int sent;
        int klen, mlen;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_beat(2'($urandom_range(3)), 8'($urandom));
                sent++;
            end else begin
                klen = ($urandom_range(9) == 0) ? $urandom_range(64, 72) : $urandom_range(0, 20);
                mlen = ($urandom_range(9) == 0) ? $urandom_range(55, 130) : $urandom_range(0, 12);
                for (int i = 0; i < klen; i++) send_beat(KIND_KEY, 8'($urandom));
                for (int i = 0; i < mlen; i++) send_beat(KIND_MSG, 8'($urandom));
                send_beat(KIND_FIN, 8'($urandom));
                sent += klen + mlen + 1;
            end
        end
        wait_drained();
    endtask

    // Receiver holds off while sender keeps offering finishes; then sender pauses.
    task automatic test_backpressure();
        recv_hold <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            send_beat(KIND_KEY, 8'($urandom));
            send_beat(KIND_FIN, 8'h00);
        end
        wait_drained();
        send_beat(KIND_MSG, 8'h42);
        send_beat(KIND_FIN, 8'h00);
        wait_drained();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_KEY;
        in_ch.data_byte = 8'h00;
        out_ch.ready = 1'b0;
        sess_phase = PH_IDLE;
        drop_key();
        md5_begin();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 7;
        recv_idle_pct = 86;
        test_random(80);
        send_idle_pct = 86;
        recv_idle_pct = 7;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(80);
        test_backpressure();

        repeat (300) @(posedge i_clk);
        if (err_count == 0 && digest_q.size() == 0) begin
            $display("tb_hmac_md5_truncated_key_top: done, clean");
        end else begin
            $display("tb_hmac_md5_truncated_key_top: done, errors");
        end
        $finish;
    end
endmodule

// ----- hmac_md5_truncated_key_top.f -----
+incdir+hw/rtl
hw/rtl/hmk_pkg.sv
hw/rtl/hmk_if.sv
hw/rtl/hmk_ram.sv
hw/rtl/hmac_md5_truncated_key_top.sv
hw/rtl/hmk_check.sv
tb/sv/tb_hmac_md5_truncated_key_top.sv
